>>> src/hadamard_matrix_element_generator_core_defines.svh
// ----------------------------------------------------------------------------
// hadamard matrix element generator: assertion macros
// clocked property checks, compiled away when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef HADAMARD_MATRIX_ELEMENT_GENERATOR_CORE_DEFINES_SVH
`define HADAMARD_MATRIX_ELEMENT_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define HMEG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hmeg assertion failed");
// property checked on every clock edge, reset included
`define HMEG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hmeg assertion failed");
`else
`define HMEG_ASSERT(lbl, clk, rst_n, prop)
`define HMEG_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/hmeg_pkg.sv
// ----------------------------------------------------------------------------
// hmeg_pkg
// types, constants and core tables of the hadamard matrix element generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hmeg_pkg;

  // field widths
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned ORDER_W = 13;
  localparam int unsigned QUO_W   = 12;
  localparam int unsigned REM_W   = 5;

  // construction selected by the configured order
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_POW2 = 2'd1,
    MODE_T20  = 2'd2,
    MODE_T12  = 2'd3
  } mode_e;

  // core sizes
  localparam int unsigned T20_N = 20;
  localparam int unsigned T12_N = 12;
  localparam int unsigned T12_PAD = T20_N - T12_N;
  localparam logic [REM_W-1:0] T20_REM_LIMIT = REM_W'(T20_N);
  localparam logic [REM_W-1:0] T12_REM_LIMIT = REM_W'(T12_N);
  localparam logic [REM_W-1:0] TBL_MSB = REM_W'(T20_N - 1);

  // largest shift tried when matching 20*2^m and 12*2^m
  localparam int unsigned ORDER_SHIFT_MAX = ORDER_W - 1;

  // reciprocal multipliers: x/5 and x/3 for 10-bit x
  localparam int unsigned QX_W        = IDX_W - 2;
  localparam int unsigned RECIP5_W    = 18;
  localparam int unsigned RECIP5_SH   = 10;
  localparam logic [RECIP5_W-1:0] RECIP5 = RECIP5_W'(205);
  localparam int unsigned RECIP3_W    = 20;
  localparam int unsigned RECIP3_SH   = 11;
  localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(683);

  // element codes
  localparam logic signed [1:0] ELEM_POS  = 2'sb01;
  localparam logic signed [1:0] ELEM_NEG  = 2'sb11;
  localparam logic signed [1:0] ELEM_ZERO = 2'sb00;

  typedef logic [T20_N-1:0] t20_row_t;
  typedef logic [T12_N-1:0] t12_row_t;

  // order-20 core, column 0 in the msb, a set bit is a minus
  localparam t20_row_t T20_ROWS [T20_N] = '{
    20'b0000_0000_0000_0000_0000,
    20'b0110_0111_1010_1000_0110,
    20'b0100_1111_0101_0000_1101,
    20'b0001_1110_1010_0001_1011,
    20'b0011_1101_0100_0011_0110,
    20'b0111_1010_1000_0110_1100,
    20'b0111_0101_0000_1101_1001,
    20'b0110_1010_0001_1011_0011,
    20'b0101_0100_0011_0110_0111,
    20'b0010_1000_0110_1100_1111,
    20'b0101_0000_1101_1001_1110,
    20'b0010_0001_1011_0011_1101,
    20'b0100_0011_0110_0111_1010,
    20'b0000_0110_1100_1111_0101,
    20'b0000_1101_1001_1110_1010,
    20'b0001_1011_0011_1101_0100,
    20'b0011_0110_0111_1010_1000,
    20'b0110_1100_1111_0101_0000,
    20'b0101_1001_1110_1010_0001,
    20'b0011_0011_1101_0100_0011
  };

  // order-12 core, column 0 in the msb, a set bit is a minus
  localparam t12_row_t T12_ROWS [T12_N] = '{
    12'b0000_0000_0000,
    12'b0110_1110_0010,
    12'b0011_0111_0001,
    12'b0101_1011_1000,
    12'b0010_1101_1100,
    12'b0001_0110_1110,
    12'b0000_1011_0111,
    12'b0100_0101_1011,
    12'b0110_0010_1101,
    12'b0111_0001_0110,
    12'b0011_1000_1011,
    12'b0101_1100_0101
  };

endpackage

>>> src/hadamard_matrix_element_generator_core.sv
// ----------------------------------------------------------------------------
// hadamard_matrix_element_generator_core
// element of a sylvester / core-kronecker hadamard matrix at (row, column)
// ----------------------------------------------------------------------------
// One element per clock at full rate, while the result side does not stall,
// through four register stages (index register, quotient stage, core row read
// and block parity stage, output register).
// A stall on the result side backs up through the stages and reaches the
// input only once all four hold a transfer. The reciprocal multiply for the
// divide by 20 or 12 and the registered read of the core row table set the
// stage split. Orders that are 2^m, 20*2^m or 12*2^m up to MAX_ORDER are
// decoded when the order register is written, so writes must happen while no
// transfer is in flight.
`timescale 1ns / 1ps

`include "hadamard_matrix_element_generator_core_defines.svh"

module hadamard_matrix_element_generator_core #(
  parameter int unsigned MAX_ORDER = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // order register write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hmeg_pkg::ORDER_W-1:0]       cfg_matrix_order_i,
  // request
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [hmeg_pkg::IDX_W-1:0]         row_index_i,
  input  logic [hmeg_pkg::IDX_W-1:0]         column_index_i,
  // result
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [1:0]                  element_value_o,
  output logic                               order_supported_o,
  output logic                               index_valid_o
);

  // order register and decoded construction
  logic [hmeg_pkg::ORDER_W-1:0] order_q, order_d;
  hmeg_pkg::mode_e              mode_q, mode_d;

  // stage 1: indices
  logic                         s1_vld_q;
  hmeg_pkg::mode_e              s1_mode_q;
  logic                         s1_idx_q;
  logic [hmeg_pkg::IDX_W-1:0]   s1_row_q, s1_col_q;

  // stage 2: quotients
  logic                         s2_vld_q;
  hmeg_pkg::mode_e              s2_mode_q;
  logic                         s2_idx_q;
  logic [hmeg_pkg::IDX_W-1:0]   s2_row_q, s2_col_q;
  logic [hmeg_pkg::QUO_W-1:0]   s2_rq_q, s2_cq_q;

  // stage 3: core row and parity
  logic                         s3_vld_q;
  hmeg_pkg::mode_e              s3_mode_q;
  logic                         s3_idx_q;
  logic                         s3_par_q;
  logic [hmeg_pkg::REM_W-1:0]   s3_cr_q;
  hmeg_pkg::t20_row_t           s3_row_q;

  // output register
  logic                         out_vld_q;
  logic signed [1:0]            out_elem_q;
  logic                         out_sup_q;
  logic                         out_idx_q;

  // stage enables
  logic out_en, s3_en, s2_en, s1_en;

  // combinational helpers
  logic                         idx_ok;
  logic [hmeg_pkg::QUO_W-1:0]   rq_d, cq_d;
  logic [hmeg_pkg::IDX_W-1:0]   rr_full, cr_full;
  logic [hmeg_pkg::REM_W-1:0]   rr, cr;
  logic                         tbl_neg, neg;

  // --------------------------------------------------------------------------
  // order register, decode of the construction on write
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [31:0] n32;
    logic        is_pow2, is_t20, is_t12, fits;
    n32     = {{(32 - hmeg_pkg::ORDER_W){1'b0}}, cfg_matrix_order_i};
    is_pow2 = (cfg_matrix_order_i != '0) &&
              ((cfg_matrix_order_i & (cfg_matrix_order_i - 1'b1)) == '0);
    is_t20  = 1'b0;
    is_t12  = 1'b0;
    for (int m = 0; m <= int'(hmeg_pkg::ORDER_SHIFT_MAX); m++) begin
      if (n32 == (32'(hmeg_pkg::T20_N) << m)) is_t20 = 1'b1;
      if (n32 == (32'(hmeg_pkg::T12_N) << m)) is_t12 = 1'b1;
    end
    fits = n32 <= 32'(MAX_ORDER);

    order_d = order_q;
    mode_d  = mode_q;
    if (cfg_valid_i && cfg_ready_o) begin
      order_d = cfg_matrix_order_i;
      if (!fits)        mode_d = hmeg_pkg::MODE_NONE;
      else if (is_pow2) mode_d = hmeg_pkg::MODE_POW2;
      else if (is_t20)  mode_d = hmeg_pkg::MODE_T20;
      else if (is_t12)  mode_d = hmeg_pkg::MODE_T12;
      else              mode_d = hmeg_pkg::MODE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= hmeg_pkg::ORDER_W'(1);
      mode_q  <= hmeg_pkg::MODE_POW2;
    end else begin
      order_q <= order_d;
      mode_q  <= mode_d;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control
  // --------------------------------------------------------------------------
  assign out_en     = !out_vld_q || !out_stall_i;
  assign s3_en      = !s3_vld_q || out_en;
  assign s2_en      = !s2_vld_q || s3_en;
  assign s1_en      = !s1_vld_q || s2_en;
  assign in_stall_o = !s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_en)  s1_vld_q  <= in_valid_i;
      if (s2_en)  s2_vld_q  <= s1_vld_q;
      if (s3_en)  s3_vld_q  <= s2_vld_q;
      if (out_en) out_vld_q <= s3_vld_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: capture indices and range check
  // --------------------------------------------------------------------------
  assign idx_ok = ({1'b0, row_index_i} < order_q) && ({1'b0, column_index_i} < order_q);

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_mode_q <= mode_q;
      s1_idx_q  <= idx_ok;
      s1_row_q  <= row_index_i;
      s1_col_q  <= column_index_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: block quotient by reciprocal multiply
  // --------------------------------------------------------------------------
  function automatic logic [hmeg_pkg::QUO_W-1:0] block_quo(
    input hmeg_pkg::mode_e            mode,
    input logic [hmeg_pkg::IDX_W-1:0] idx
  );
    logic [hmeg_pkg::QX_W-1:0]     x;
    logic [hmeg_pkg::RECIP5_W-1:0] p5;
    logic [hmeg_pkg::RECIP3_W-1:0] p3;
    x  = idx[hmeg_pkg::IDX_W-1:2];
    p5 = hmeg_pkg::RECIP5_W'(x) * hmeg_pkg::RECIP5;
    p3 = hmeg_pkg::RECIP3_W'(x) * hmeg_pkg::RECIP3;
    case (mode)
      hmeg_pkg::MODE_T20: block_quo = hmeg_pkg::QUO_W'(p5 >> hmeg_pkg::RECIP5_SH);
      hmeg_pkg::MODE_T12: block_quo = hmeg_pkg::QUO_W'(p3 >> hmeg_pkg::RECIP3_SH);
      default:            block_quo = idx;
    endcase
  endfunction

  assign rq_d = block_quo(s1_mode_q, s1_row_q);
  assign cq_d = block_quo(s1_mode_q, s1_col_q);

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_vld_q) begin
      s2_mode_q <= s1_mode_q;
      s2_idx_q  <= s1_idx_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_rq_q   <= rq_d;
      s2_cq_q   <= cq_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: remainders, core row read, block parity
  // --------------------------------------------------------------------------
  function automatic logic [hmeg_pkg::IDX_W-1:0] block_rem(
    input hmeg_pkg::mode_e             mode,
    input logic [hmeg_pkg::IDX_W-1:0]  idx,
    input logic [hmeg_pkg::QUO_W-1:0]  quo
  );
    case (mode)
      hmeg_pkg::MODE_T20: block_rem = idx - ((quo << 4) + (quo << 2));
      hmeg_pkg::MODE_T12: block_rem = idx - ((quo << 3) + (quo << 2));
      default:            block_rem = '0;
    endcase
  endfunction

  assign rr_full = block_rem(s2_mode_q, s2_row_q, s2_rq_q);
  assign cr_full = block_rem(s2_mode_q, s2_col_q, s2_cq_q);
  assign rr      = rr_full[hmeg_pkg::REM_W-1:0];
  assign cr      = cr_full[hmeg_pkg::REM_W-1:0];

  // core table read, registered
  always_ff @(posedge clk_i) begin
    if (s3_en && s2_vld_q) begin
      s3_mode_q <= s2_mode_q;
      s3_idx_q  <= s2_idx_q;
      s3_par_q  <= ^(s2_rq_q & s2_cq_q);
      s3_cr_q   <= cr;
      case (s2_mode_q)
        hmeg_pkg::MODE_T12:
          s3_row_q <= {hmeg_pkg::T12_ROWS[rr[hmeg_pkg::REM_W-2:0]],
                       hmeg_pkg::T12_PAD'(0)};
        hmeg_pkg::MODE_T20:
          s3_row_q <= hmeg_pkg::T20_ROWS[rr];
        default:
          s3_row_q <= '0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // output register: sign and flags
  // --------------------------------------------------------------------------
  assign tbl_neg = s3_row_q[hmeg_pkg::TBL_MSB - s3_cr_q];
  assign neg     = s3_par_q ^ tbl_neg;

  always_ff @(posedge clk_i) begin
    if (out_en && s3_vld_q) begin
      out_sup_q <= (s3_mode_q != hmeg_pkg::MODE_NONE);
      out_idx_q <= s3_idx_q;
      if ((s3_mode_q != hmeg_pkg::MODE_NONE) && s3_idx_q) begin
        out_elem_q <= neg ? hmeg_pkg::ELEM_NEG : hmeg_pkg::ELEM_POS;
      end else begin
        out_elem_q <= hmeg_pkg::ELEM_ZERO;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign element_value_o   = out_elem_q;
  assign order_supported_o = out_sup_q;
  assign index_valid_o     = out_idx_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // element is zero exactly when the order is unsupported or the index is out
  `HMEG_ASSERT(a_elem_zero, clk_i, rst_ni, out_vld_q |-> ((out_elem_q == hmeg_pkg::ELEM_ZERO) == !(out_sup_q && out_idx_q)))
  // input stalls only with every stage full and the output held
  `HMEG_ASSERT(a_stall_full, clk_i, rst_ni, in_stall_o |-> (s1_vld_q && s2_vld_q && s3_vld_q && out_vld_q && out_stall_i))
  // reciprocal quotient leaves a remainder inside the core
  `HMEG_ASSERT(a_rem_range, clk_i, rst_ni, s3_vld_q |-> ((s3_cr_q < hmeg_pkg::T20_REM_LIMIT) && (s3_mode_q != hmeg_pkg::MODE_T12 || s3_cr_q < hmeg_pkg::T12_REM_LIMIT)))
  // power-of-two decode agrees with the stored order
  `HMEG_ASSERT_ALWAYS(a_pow2_order, clk_i, (mode_q == hmeg_pkg::MODE_POW2) |-> $onehot(order_q))

endmodule
